/* rtl/jrfp_pkg.sv */
// ----------------------------------------------------------------------------
// jrfp_pkg
// Shared constants and types for the joint report frame parser.
// ----------------------------------------------------------------------------
package jrfp_pkg;

    // frame byte store: 64 bytes, kept as 16 words of 4 byte lanes
    localparam int STORE_DEPTH = 64;
    localparam int STORE_WORDS = 16;
    localparam int LANES       = 4;

    // header pair and length adjust
    localparam logic [7:0] HDR_BYTE0  = 8'h55;
    localparam logic [7:0] HDR_BYTE1  = 8'hAA;
    localparam logic [8:0] LEN_ADJUST = 9'd6;

    // byte position of the length byte and of the first payload byte
    localparam logic [7:0] LEN_BYTE_POS   = 8'd4;
    localparam logic [7:0] FRAME_START_POS = 8'd2;

    // joint whose position is taken as a clamped gripper value
    localparam logic [2:0] GRIPPER_JOINT = 3'd6;

    // reset values
    localparam logic [7:0]  ID_RESET      = 8'd2;
    localparam logic [15:0] SPAN_RESET    = 16'd50000;
    localparam logic [8:0]  EXP_LEN_RESET = 9'd14;

    // configuration register indexes
    localparam int          CFG_IDX_W           = 2;
    localparam logic [1:0]  REG_REPORT_FRAME_ID = 2'd0;
    localparam logic [1:0]  REG_GRIPPER_SPAN    = 2'd1;
    localparam int          CFG_DATA_W          = 16;

    // result packing: index, current, position, count, zero fill
    localparam int OUT_DATA_W = 104;

    typedef logic [LANES-1:0][7:0] store_word_t;

endpackage

/* rtl/joint_report_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// joint_report_frame_parser_unit
// Byte stream parser for joint report frames: stores frame bytes in a small
// lane-wise RAM and reads them back to emit one result per joint of a frame whose id matches.
// ----------------------------------------------------------------------------
// Throughput: one byte request per cycle while the sequencer is idle. A completing
//   frame holds the input through the id word read and check and, on a match,
//   through the current read, position read and result output of each joint,
//   longer if the result side stalls; this is set by the single frame store read port.
// First result: id word read, id check, current read, position read, then result load.
// Reset: aresetn synchronous, active low; store reads as zeros after reset.
module joint_report_frame_parser_unit #(
    parameter int MAX_FRAME_BYTES = 128,
    parameter int JOINT_COUNT     = 7
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [jrfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jrfp_pkg::CFG_DATA_W-1:0]    cfg_data,
    // received bytes
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] rx_byte
    // joint results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] joint_index, [34:3] joint_current, [66:35] joint_position,
    // [98:67] frames_counted, [103:99] zero
    output logic [jrfp_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tlast    // last_joint
);

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RID  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_RCUR = 3'd3;
    localparam logic [2:0] S_RPOS = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic [7:0]   id_reg;
    logic [15:0]  span_reg;
    logic         in_frame_reg;
    logic [7:0]   prev_reg;
    logic [PW-1:0] pos_reg;
    logic [8:0]   exp_len_reg;
    logic [31:0]  count_reg;
    logic [2:0]   joint_reg;
    logic [31:0]  cur_reg;

    logic                         m_tvalid_reg;
    logic [jrfp_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic                         m_tlast_reg;

    // frame store and its valid bits
    jrfp_pkg::store_word_t store_mem [jrfp_pkg::STORE_WORDS];
    logic [jrfp_pkg::STORE_WORDS-1:0][jrfp_pkg::LANES-1:0] vld_reg;
    jrfp_pkg::store_word_t        mem_q;
    logic [jrfp_pkg::LANES-1:0]   vld_q;

    logic         byte_req;
    logic         hdr_hit;
    logic         wr_en;
    logic [5:0]   wr_baddr;
    logic [3:0]   rd_addr;
    logic         rd_en;
    logic [PW-1:0] pos_inc;
    logic [8:0]   exp_eff;
    logic         frame_done;
    logic [31:0]  rd_word;
    logic [31:0]  pos_word;
    logic [31:0]  grip_val;
    logic         out_load;
    logic         last_j;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign byte_req  = s_tvalid && s_tready;

    // store write: byte p lives at byte address p-1; bytes 0 and 1 are never read
    assign wr_baddr = 6'(pos_reg - PW'(1));
    assign wr_en    = byte_req && (pos_reg < PW'(jrfp_pkg::STORE_DEPTH))
                      && (pos_reg != '0);

    assign hdr_hit = !in_frame_reg && (prev_reg == jrfp_pkg::HDR_BYTE0)
                     && (s_tdata == jrfp_pkg::HDR_BYTE1);

    // in-frame position and length tracking
    assign pos_inc = pos_reg + PW'(1);
    assign exp_eff = (pos_reg == PW'(jrfp_pkg::LEN_BYTE_POS))
                     ? ({1'b0, s_tdata} + jrfp_pkg::LEN_ADJUST) : exp_len_reg;
    assign frame_done = in_frame_reg && (9'(pos_inc) == exp_eff);

    // read address per sequencer state
    always_comb begin
        rd_addr = '0;
        rd_en   = 1'b0;
        unique case (state_reg)
            S_RID:  begin rd_addr = 4'd0; rd_en = 1'b1; end
            S_RCUR: begin rd_addr = 4'({joint_reg, 1'b0} + 4'd1); rd_en = 1'b1; end
            S_RPOS: begin rd_addr = 4'({joint_reg, 1'b0} + 4'd2); rd_en = 1'b1; end
            default: begin rd_addr = '0; rd_en = 1'b0; end
        endcase
    end

    // read word, big-endian over lanes, unwritten lanes read as zero
    assign rd_word = {vld_q[0] ? mem_q[0] : 8'd0, vld_q[1] ? mem_q[1] : 8'd0,
                      vld_q[2] ? mem_q[2] : 8'd0, vld_q[3] ? mem_q[3] : 8'd0};
    assign pos_word = rd_word;

    // gripper: span minus raw, clamped to 0..span
    always_comb begin
        if (pos_word[31]) begin
            grip_val = {16'd0, span_reg};
        end else if (pos_word > {16'd0, span_reg}) begin
            grip_val = '0;
        end else begin
            grip_val = {16'd0, span_reg - pos_word[15:0]};
        end
    end

    assign last_j   = (joint_reg == 3'(JOINT_COUNT - 1));
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (byte_req && !hdr_hit && frame_done) state_next = S_RID;
            S_RID:  state_next = S_CHK;
            S_CHK:  state_next = (rd_word[23:16] == id_reg) ? S_RCUR : S_IDLE;
            S_RCUR: state_next = S_RPOS;
            S_RPOS: state_next = S_OUT;
            S_OUT:  if (out_load) state_next = last_j ? S_IDLE : S_RCUR;
            default: state_next = S_IDLE;
        endcase
    end

    // frame store RAM
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_baddr[5:2]][wr_baddr[1:0]] <= s_tdata;
        end
        if (rd_en) begin
            mem_q <= store_mem[rd_addr];
            vld_q <= vld_reg[rd_addr];
        end
    end

    // control and parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            id_reg       <= jrfp_pkg::ID_RESET;
            span_reg     <= jrfp_pkg::SPAN_RESET;
            in_frame_reg <= 1'b0;
            prev_reg     <= '0;
            pos_reg      <= '0;
            exp_len_reg  <= jrfp_pkg::EXP_LEN_RESET;
            count_reg    <= '0;
            joint_reg    <= '0;
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    jrfp_pkg::REG_REPORT_FRAME_ID: id_reg   <= cfg_data[7:0];
                    jrfp_pkg::REG_GRIPPER_SPAN:    span_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (wr_en) begin
                vld_reg[wr_baddr[5:2]][wr_baddr[1:0]] <= 1'b1;
            end

            // byte parsing
            if (byte_req) begin
                if (hdr_hit) begin
                    in_frame_reg <= 1'b1;
                    pos_reg      <= PW'(jrfp_pkg::FRAME_START_POS);
                    prev_reg     <= '0;
                end else if (!in_frame_reg) begin
                    prev_reg <= s_tdata;
                end else begin
                    exp_len_reg <= exp_eff;
                    pos_reg     <= pos_inc;
                    if (frame_done || (pos_inc >= PW'(MAX_FRAME_BYTES))) begin
                        in_frame_reg <= 1'b0;
                    end
                end
            end

            // id check counts the frame; joint counter holds on the last joint
            if (state_reg == S_CHK && state_next == S_RCUR) begin
                count_reg <= count_reg + 32'd1;
                joint_reg <= '0;
            end else if (out_load && !last_j) begin
                joint_reg <= joint_reg + 3'd1;
            end

            // result register
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (state_reg == S_RPOS) begin
            cur_reg <= rd_word;
        end
        if (out_load) begin
            m_tdata_reg <= {5'd0, count_reg,
                            (joint_reg == jrfp_pkg::GRIPPER_JOINT) ? grip_val : pos_word,
                            cur_reg, joint_reg};
            m_tlast_reg <= last_j;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // joint counter stays inside the configured joint range
    a_joint_range: assert property (@(posedge aclk) disable iff (!aresetn)
        joint_reg <= 3'(JOINT_COUNT - 1))
        else $error("joint counter out of range");

    // an open frame never sits at or past the abort length
    a_frame_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        in_frame_reg |-> (pos_reg < PW'(MAX_FRAME_BYTES)))
        else $error("open frame past abort length");

    // frame count moves only after an id check
    a_count_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |-> $past(state_reg == S_CHK))
        else $error("frame count changed outside id check");

    // the final result of a frame returns the sequencer to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_j) |=> (state_reg == S_IDLE))
        else $error("sequencer did not finish after last joint");

endmodule
